>>> sv/xsfb_pkg.sv
// ----------------------------------------------------------------------------
// XOR sprite frame buffer package
// Shared constants, codes, types and a helper function of the frame buffer.
// ----------------------------------------------------------------------------
package xsfb_pkg;

  localparam int unsigned MaxPixels     = 8192;
  localparam int unsigned MaxSpriteRows = 16;
  localparam int unsigned AddrW         = $clog2(MaxPixels);
  localparam int unsigned PixIdxW       = 13;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } xsfb_op_e;

  typedef enum logic [1:0] {
    MODE_64X32  = 2'd0,
    MODE_128X64 = 2'd1,
    MODE_64X48  = 2'd2,
    MODE_64X64  = 2'd3
  } xsfb_mode_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DRAW,
    ST_READ,
    ST_FETCH,
    ST_DONE
  } xsfb_state_e;

  typedef struct packed {
    logic [7:0] y;
    logic [3:0] ri;
    logic [6:0] col;
  } xsfb_loc_req_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic             in_range;
  } xsfb_loc_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic             data;
  } xsfb_wr_t;

  // Remainder by three of a five-bit value in four conditional subtractions.
  function automatic logic [1:0] mod3_5b(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (r >= 5'd24) r = r - 5'd24;
    if (r >= 5'd12) r = r - 5'd12;
    if (r >= 5'd6)  r = r - 5'd6;
    if (r >= 5'd3)  r = r - 5'd3;
    return r[1:0];
  endfunction

endpackage

>>> sv/xsfb_if.sv
// ----------------------------------------------------------------------------
// XOR sprite frame buffer channels
// Valid/ready channels for the request and the response of the frame buffer.
// ----------------------------------------------------------------------------
interface xsfb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] x_pos;
  logic [7:0] y_pos;
  logic [3:0] row_index;
  logic [7:0] sprite_row;

  modport source (output valid, operation, x_pos, y_pos, row_index, sprite_row,
                  input ready);
  modport sink (input valid, operation, x_pos, y_pos, row_index, sprite_row,
                output ready);
endinterface

interface xsfb_rsp_if;
  logic valid;
  logic ready;
  logic collision;
  logic pixel_value;

  modport source (output valid, collision, pixel_value, input ready);
  modport sink (input valid, collision, pixel_value, output ready);
endinterface

>>> sv/xsfb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module xsfb_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/xsfb_addr.sv
// ----------------------------------------------------------------------------
// XOR sprite frame buffer address unit
// Wraps the row for the screen height and forms the pixel address.
// ----------------------------------------------------------------------------
module xsfb_addr import xsfb_pkg::*; (
  input  xsfb_mode_e    mode_i,
  input  xsfb_loc_req_t loc_req_i,
  output xsfb_loc_t     loc_o
);

  logic [8:0]         rsum;
  logic [5:0]         row;
  logic [PixIdxW-1:0] idx;

  always_comb begin
    rsum = 9'(loc_req_i.y) + 9'(loc_req_i.ri);
    case (mode_i)
      MODE_64X32:  row = {1'b0, rsum[4:0]};
      MODE_128X64: row = rsum[5:0];
      MODE_64X48:  row = {mod3_5b(rsum[8:4]), rsum[3:0]};
      MODE_64X64:  row = rsum[5:0];
      default:     row = rsum[5:0];
    endcase
    if (mode_i == MODE_128X64) begin
      idx = {row, loc_req_i.col};
    end else begin
      idx = {1'b0, row, loc_req_i.col[5:0]};
    end
    loc_o.addr     = idx[AddrW-1:0];
    loc_o.in_range = ({1'b0, idx} < (PixIdxW + 1)'(MaxPixels));
  end

endmodule

>>> sv/xsfb_seq.sv
// ----------------------------------------------------------------------------
// XOR sprite frame buffer sequencer
// Steps each request through the clear sweep, the pixel read-modify-write or read, and the result.
// ----------------------------------------------------------------------------
module xsfb_seq import xsfb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  xsfb_mode_e          mode_i,
  xsfb_req_if.sink            req_i,
  xsfb_rsp_if.source          rsp_o,
  output xsfb_loc_req_t       loc_req_o,
  input  xsfb_loc_t           loc_i,
  output xsfb_wr_t            wr_o,
  output logic [AddrW-1:0]    raddr_o,
  input  logic                rdata_i
);

  xsfb_state_e      state_q, state_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic             clr_rsp_q, clr_rsp_d;
  logic             coll_q, coll_d;
  logic             prev_ok_q, prev_ok_d;
  logic             out_valid_q, out_valid_d;
  logic             out_coll_q, out_coll_d;
  logic             out_pv_q, out_pv_d;
  logic [1:0]       op_q;
  logic [7:0]       y_q;
  logic [3:0]       ri_q;
  logic [7:0]       bits_q, bits_d;
  logic [6:0]       col_q, col_d;
  logic [AddrW-1:0] prev_addr_q, prev_addr_d;
  logic             prev_sbit_q, prev_sbit_d;
  logic             pv_q, pv_d;
  logic             req_fire;
  logic             ri_ok;
  logic             sweep_last;
  logic             out_free;
  logic [6:0]       col_init;
  logic [6:0]       col_inc;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign ri_ok       = (int'(req_i.row_index) < MaxSpriteRows);
  assign sweep_last  = (clr_cnt_q == AddrW'(MaxPixels - 1));
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign col_init = (mode_i == MODE_128X64) ? req_i.x_pos[6:0] : {1'b0, req_i.x_pos[5:0]};
  assign col_inc  = (mode_i == MODE_128X64) ? col_q + 7'd1 : {1'b0, col_q[5:0] + 6'd1};

  assign loc_req_o.y   = y_q;
  assign loc_req_o.ri  = ri_q;
  assign loc_req_o.col = col_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SWEEP: begin
        if (sweep_last) state_d = clr_rsp_q ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (req_fire) begin
          case (req_i.operation)
            OP_CLEAR: state_d = ST_SWEEP;
            OP_DRAW:  state_d = ri_ok ? ST_DRAW : ST_DONE;
            OP_READ:  state_d = ST_READ;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_DRAW: begin
        if (cnt_q == 4'd8) state_d = ST_DONE;
      end
      ST_READ:  state_d = ST_FETCH;
      ST_FETCH: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    clr_cnt_d   = clr_cnt_q;
    clr_rsp_d   = clr_rsp_q;
    coll_d      = coll_q;
    prev_ok_d   = prev_ok_q;
    prev_addr_d = prev_addr_q;
    prev_sbit_d = prev_sbit_q;
    bits_d      = bits_q;
    col_d       = col_q;
    pv_d        = pv_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_coll_d  = out_coll_q;
    out_pv_d    = out_pv_q;
    wr_o.en     = 1'b0;
    wr_o.addr   = prev_addr_q;
    wr_o.data   = rdata_i ^ prev_sbit_q;
    raddr_o     = loc_i.addr;
    case (state_q)
      ST_SWEEP: begin
        wr_o.en   = 1'b1;
        wr_o.addr = clr_cnt_q;
        wr_o.data = 1'b0;
        clr_cnt_d = sweep_last ? '0 : clr_cnt_q + AddrW'(1);
      end
      ST_IDLE: begin
        if (req_fire) begin
          cnt_d     = '0;
          prev_ok_d = 1'b0;
          pv_d      = 1'b0;
          bits_d    = req_i.sprite_row;
          col_d     = col_init;
          clr_rsp_d = (req_i.operation == OP_CLEAR);
          if (req_i.operation == OP_DRAW && ri_ok && req_i.row_index == '0) begin
            coll_d = 1'b0;
          end
        end
      end
      ST_DRAW: begin
        wr_o.en     = prev_ok_q;
        prev_addr_d = loc_i.addr;
        prev_ok_d   = loc_i.in_range && (cnt_q != 4'd8);
        prev_sbit_d = bits_q[7];
        bits_d      = {bits_q[6:0], 1'b0};
        col_d       = col_inc;
        cnt_d       = cnt_q + 4'd1;
        if (prev_ok_q && rdata_i && prev_sbit_q) coll_d = 1'b1;
      end
      ST_READ: begin
        prev_ok_d = loc_i.in_range;
      end
      ST_FETCH: begin
        pv_d = prev_ok_q && rdata_i;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_coll_d  = coll_q;
          out_pv_d    = pv_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      cnt_q       <= '0;
      clr_cnt_q   <= '0;
      clr_rsp_q   <= 1'b0;
      coll_q      <= 1'b0;
      prev_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_rsp_q   <= clr_rsp_d;
      coll_q      <= coll_d;
      prev_ok_q   <= prev_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q <= req_i.operation;
      y_q  <= req_i.y_pos;
      ri_q <= (req_i.operation == OP_READ) ? 4'd0 : req_i.row_index;
    end
    bits_q      <= bits_d;
    col_q       <= col_d;
    prev_addr_q <= prev_addr_d;
    prev_sbit_q <= prev_sbit_d;
    pv_q        <= pv_d;
    out_coll_q  <= out_coll_d;
    out_pv_q    <= out_pv_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.collision   = out_coll_q;
  assign rsp_o.pixel_value = out_pv_q;

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !wr_o.en)
    else $error("frame buffer written while idle");

  a_row0_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.operation == OP_DRAW && req_i.row_index == 4'd0) |=> !coll_q)
    else $error("collision flag not cleared by sprite row zero");

  a_draw_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW) |-> (cnt_q <= 4'd8))
    else $error("draw step count out of range");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result not loaded on completion");

  a_op_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW) |-> (op_q == OP_DRAW))
    else $error("draw sequence running for another operation");
`endif

endmodule

>>> sv/xor_sprite_frame_buffer.sv
// ----------------------------------------------------------------------------
// XOR sprite frame buffer
// Monochrome frame buffer with clear, XOR sprite row draw and pixel read.
//
//   Channel  Dir  Handshake            Payload
//   req_i    in   valid / ready        operation, x_pos, y_pos, row_index,
//                                      sprite_row
//   rsp_o    out  valid / ready        collision, pixel_value
//   cfg      in   cfg_we_i             cfg_wdata_i (display mode)
//
// A draw does one read-modify-write per pixel on the single frame RAM,
// overlapped over nine steps. A clear writes one RAM entry a cycle.
// After reset a clearing pass over all MaxPixels entries runs before the first transfer.
// The response register lets a new request start while a result waits.
// ----------------------------------------------------------------------------
module xor_sprite_frame_buffer import xsfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  xsfb_req_if.sink   req_i,
  xsfb_rsp_if.source rsp_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);

  xsfb_mode_e       mode_q;
  xsfb_loc_req_t    loc_req;
  xsfb_loc_t        loc;
  xsfb_wr_t         wr;
  logic [AddrW-1:0] raddr;
  logic             rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_64X32;
    end else if (cfg_we_i) begin
      mode_q <= xsfb_mode_e'(cfg_wdata_i);
    end
  end

  xsfb_addr u_addr (
    .mode_i    (mode_q),
    .loc_req_i (loc_req),
    .loc_o     (loc)
  );

  xsfb_ram #(
    .Width (1),
    .Depth (MaxPixels)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  xsfb_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_i    (mode_q),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .loc_req_o (loc_req),
    .loc_i     (loc),
    .wr_o      (wr),
    .raddr_o   (raddr),
    .rdata_i   (rdata)
  );

endmodule
